// ===== hw/rtl/cho_pkg.sv =====
// Shared types, constants and calendar helpers for the hour offset converter.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps

package cho_pkg;

    localparam int YEAR_BITS_DEF = 14;

    // register reset values
    localparam int REF_YEAR_RST = 2000;
    localparam logic [4:0] REF_DAY_RST   = 5'd1;
    localparam logic [3:0] REF_MONTH_RST = 4'd1;
    localparam logic [4:0] REF_HOUR_RST  = 5'd0;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // signed hour accumulator, day counter and day-of-year widths
    // (sized for YEAR_BITS up to 16)
    localparam int ACC_W = 34;
    localparam int DAY_W = 28;
    localparam int DOY_W = 9;

    // x / 100 = (x * DIV100_MAGIC) >> DIV100_SHIFT, exact for x < 2^17
    localparam int DIV100_SHIFT = 24;
    localparam int DIV100_MAGIC_W = 18;
    localparam logic [DIV100_MAGIC_W-1:0] DIV100_MAGIC = 18'd167773;

    // x / 3 = (x * DIV3_MAGIC) >> DIV3_SHIFT, exact for x < 2^29
    localparam int DIV3_SHIFT = 31;
    localparam int DIV3_IN_W = 29;
    localparam int DIV3_MAGIC_W = 30;
    localparam logic [DIV3_MAGIC_W-1:0] DIV3_MAGIC = 30'd715827883;

    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

    localparam logic [8:0] MONTH_START [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef enum logic [1:0] {
        REG_DAY   = 2'd0,
        REG_MONTH = 2'd1,
        REG_YEAR  = 2'd2,
        REG_HOUR  = 2'd3
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_DATE_TO_OFFSET = 1'b0,
        OP_OFFSET_TO_DATE = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Y_ISSUE,
        ST_Y_WAIT,
        ST_Y_DAYS,
        ST_Y_HOURS,
        ST_DIFF,
        ST_OFF_ADD,
        ST_DIV_MUL,
        ST_DIV_REM,
        ST_S_ISSUE,
        ST_S_WAIT,
        ST_S_CMP,
        ST_M_ISSUE,
        ST_M_WAIT,
        ST_M_SET,
        ST_M_WALK
    } state_t;

    // days in the year before month m; month 0 counts as January,
    // months past December count the whole year
    function automatic logic [8:0] days_before_month(input logic [3:0] m,
                                                     input logic leap);
        logic [3:0] k;
        logic [8:0] d;
        if (m == 4'd0)
            k = 4'd0;
        else if (m > 4'd13)
            k = MONTHS_PER_YEAR;
        else
            k = m - 4'd1;
        d = MONTH_START[k];
        if (k >= 4'd2 && leap)
            d = d + 9'd1;
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/cho_regs.sv =====
// APB register file holding the reference date and hour.
// Depends on cho_pkg.
`timescale 1ns / 1ps

module cho_regs #(
    parameter int YEAR_BITS = cho_pkg::YEAR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cho_pkg::ADDR_W-1:0]  paddr,
    input  logic [cho_pkg::DATA_W-1:0]  pwdata,
    output logic [cho_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [4:0]                  ref_day,
    output logic [3:0]                  ref_month,
    output logic [YEAR_BITS-1:0]        ref_year,
    output logic [4:0]                  ref_hour
);
    import cho_pkg::*;

    logic [4:0]           ref_day_reg;
    logic [3:0]           ref_month_reg;
    logic [YEAR_BITS-1:0] ref_year_reg;
    logic [4:0]           ref_hour_reg;
    logic                 wr_en;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_day_reg   <= REF_DAY_RST;
            ref_month_reg <= REF_MONTH_RST;
            ref_year_reg  <= YEAR_BITS'(REF_YEAR_RST);
            ref_hour_reg  <= REF_HOUR_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DAY:   ref_day_reg   <= pwdata[4:0];
                REG_MONTH: ref_month_reg <= pwdata[3:0];
                REG_YEAR:  ref_year_reg  <= pwdata[YEAR_BITS-1:0];
                REG_HOUR:  ref_hour_reg  <= pwdata[4:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DAY:   prdata = DATA_W'(ref_day_reg);
            REG_MONTH: prdata = DATA_W'(ref_month_reg);
            REG_YEAR:  prdata = DATA_W'(ref_year_reg);
            REG_HOUR:  prdata = DATA_W'(ref_hour_reg);
            default:   prdata = '0;
        endcase
    end

    assign ref_day   = ref_day_reg;
    assign ref_month = ref_month_reg;
    assign ref_year  = ref_year_reg;
    assign ref_hour  = ref_hour_reg;

endmodule

// ===== hw/rtl/cho_year_unit.sv =====
// Shared two-stage unit: days from 1 Jan of year 0 to 1 Jan of a year, and its leap flag.
// Depends on cho_pkg. The year and ceil(year/100) are registered first, then the day count and leap flag.
`timescale 1ns / 1ps

module cho_year_unit #(
    parameter int YEAR_BITS = cho_pkg::YEAR_BITS_DEF
) (
    input  logic                 clk,
    input  logic [YEAR_BITS:0]   year,
    output logic [YEAR_BITS+8:0] dby,
    output logic                 leap
);
    import cho_pkg::*;

    localparam int YW = YEAR_BITS + 1;
    localparam int XW = YEAR_BITS + 2;
    localparam int DW = YEAR_BITS + 9;
    localparam int PW = DIV100_SHIFT + YW;
    localparam int QW = YW + 7;

    logic [YW-1:0] y_s1_reg;
    logic [YW-1:0] q_reg;
    logic [PW-1:0] prod;
    logic [XW-1:0] y_up;
    logic [DW-1:0] y_dw;
    logic [DW-1:0] y365;
    logic [DW-1:0] c4;
    logic [DW-1:0] c400;
    logic [YW:0]   q_up;
    logic [QW-1:0] q100;
    logic          div100;
    logic [DW-1:0] dby_reg;
    logic          leap_reg;

    // q = ceil(year / 100)
    assign y_up = XW'(year) + XW'(99);
    assign prod = PW'(y_up) * PW'(DIV100_MAGIC);

    always_ff @(posedge clk)
    begin
        y_s1_reg <= year;
        q_reg    <= prod[DIV100_SHIFT +: YW];
    end

    assign y_dw = DW'(y_s1_reg);
    assign y365 = (y_dw << 8) + (y_dw << 6) + (y_dw << 5) + (y_dw << 3) + (y_dw << 2) + y_dw;
    assign c4   = DW'((XW'(y_s1_reg) + XW'(3)) >> 2);
    // ceil(y/400) = ceil(ceil(y/100)/4)
    assign q_up = (YW + 1)'(q_reg) + (YW + 1)'(3);
    assign c400 = DW'(q_up >> 2);
    assign q100 = (QW'(q_reg) << 6) + (QW'(q_reg) << 5) + (QW'(q_reg) << 2);
    assign div100 = (q100 == QW'(y_s1_reg));

    always_ff @(posedge clk)
    begin
        dby_reg  <= y365 + c4 - DW'(q_reg) + c400;
        leap_reg <= (y_s1_reg[1:0] == 2'b00) && (!div100 || q_reg[1:0] == 2'b00);
    end

    assign dby  = dby_reg;
    assign leap = leap_reg;

endmodule

// ===== hw/rtl/cho_core.sv =====
// Sequencer and datapath for both conversions; drives the shared year unit.
// Depends on cho_pkg and on the year unit's register stages, which the ISSUE and WAIT states cover.
`timescale 1ns / 1ps

module cho_core #(
    parameter int YEAR_BITS = cho_pkg::YEAR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           ref_day,
    input  logic [3:0]           ref_month,
    input  logic [YEAR_BITS-1:0] ref_year,
    input  logic [4:0]           ref_hour,
    input  logic                 start,
    output logic                 busy,
    input  logic                 opcode,
    input  logic [4:0]           in_day,
    input  logic [3:0]           in_month,
    input  logic [YEAR_BITS-1:0] in_year,
    input  logic [4:0]           in_hour,
    input  logic signed [31:0]   in_offset,
    output logic [YEAR_BITS:0]   yu_year,
    input  logic [YEAR_BITS+8:0] yu_dby,
    input  logic                 yu_leap,
    output logic                 done,
    output logic signed [31:0]   out_offset,
    output logic [4:0]           out_day,
    output logic [3:0]           out_month,
    output logic [YEAR_BITS-1:0] out_year,
    output logic [4:0]           out_hour,
    output logic                 out_of_range
);
    import cho_pkg::*;

    localparam int YW    = YEAR_BITS + 1;
    localparam int BIT_W = $clog2(YEAR_BITS + 1);
    localparam int P3W   = DIV3_IN_W + DIV3_MAGIC_W;

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;

    opcode_t              op_reg, op_next;
    logic                 phase_reg, phase_next;
    logic [4:0]           day_in_reg, day_in_next;
    logic [3:0]           mon_in_reg, mon_in_next;
    logic [YEAR_BITS-1:0] yr_in_reg, yr_in_next;
    logic [4:0]           hr_in_reg, hr_in_next;
    logic signed [31:0]   off_reg, off_next;

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     base_reg, base_next;
    logic [DAY_W-1:0]     days_reg, days_next;
    logic [4:0]           hrs_reg, hrs_next;
    logic [YW-1:0]        year_reg, year_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [DOY_W-1:0]     doy_reg, doy_next;
    logic [3:0]           mon_reg, mon_next;
    logic                 leap_reg, leap_next;

    logic signed [31:0]   out_offset_reg, out_offset_next;
    logic [4:0]           out_day_reg, out_day_next;
    logic [3:0]           out_month_reg, out_month_next;
    logic [YEAR_BITS-1:0] out_year_reg, out_year_next;
    logic [4:0]           out_hour_reg, out_hour_next;
    logic                 oor_reg, oor_next;

    // datapath
    logic [4:0]           sel_day;
    logic [3:0]           sel_month;
    logic [4:0]           sel_hour;
    logic [8:0]           dbm;
    logic [ACC_W-1:0]     days_sum;
    logic [ACC_W-1:0]     hours_sum;
    logic [ACC_W-1:0]     off_sum;
    logic [ACC_W-1:0]     diff;
    logic [P3W-1:0]       prod3;
    logic [ACC_W-1:0]     rem24;
    logic [YW-1:0]        cand;
    logic [DAY_W-1:0]     dby_days;
    logic                 hit;
    logic [DAY_W-1:0]     doy_full;
    logic [4:0]           mlen;

    assign sel_day   = phase_reg ? day_in_reg : ref_day;
    assign sel_month = phase_reg ? mon_in_reg : ref_month;
    assign sel_hour  = phase_reg ? hr_in_reg  : ref_hour;

    assign dbm       = days_before_month(sel_month, yu_leap);
    assign days_sum  = ACC_W'(yu_dby) + ACC_W'(dbm) + ACC_W'(sel_day) - ACC_W'(1);
    assign hours_sum = (acc_reg << 4) + (acc_reg << 3) + ACC_W'(sel_hour);
    assign off_sum   = base_reg + ACC_W'(off_reg);
    assign diff      = acc_reg - base_reg;

    // hours / 24 = (hours / 8) / 3
    assign prod3 = P3W'(acc_reg[31:3]) * P3W'(DIV3_MAGIC);
    assign rem24 = acc_reg - (ACC_W'(days_reg) << 4) - (ACC_W'(days_reg) << 3);

    assign cand     = year_reg | (YW'(1) << bit_reg);
    assign dby_days = DAY_W'(yu_dby);
    assign hit      = (dby_days <= days_reg);
    assign doy_full = days_reg - dby_days;
    assign mlen     = month_len(mon_reg, leap_reg);

    always_comb
    begin
        case (state_reg)
            ST_Y_ISSUE: yu_year = phase_reg ? YW'(yr_in_reg) : YW'(ref_year);
            ST_S_ISSUE: yu_year = cand;
            default:    yu_year = year_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        phase_next      = phase_reg;
        day_in_next     = day_in_reg;
        mon_in_next     = mon_in_reg;
        yr_in_next      = yr_in_reg;
        hr_in_next      = hr_in_reg;
        off_next        = off_reg;
        acc_next        = acc_reg;
        base_next       = base_reg;
        days_next       = days_reg;
        hrs_next        = hrs_reg;
        year_next       = year_reg;
        bit_next        = bit_reg;
        doy_next        = doy_reg;
        mon_next        = mon_reg;
        leap_next       = leap_reg;
        out_offset_next = out_offset_reg;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_hour_next   = out_hour_reg;
        oor_next        = oor_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = opcode_t'(opcode);
                    day_in_next = in_day;
                    mon_in_next = in_month;
                    yr_in_next  = in_year;
                    hr_in_next  = in_hour;
                    off_next    = in_offset;
                    phase_next  = 1'b0;
                    state_next  = ST_Y_ISSUE;
                end
            end
            ST_Y_ISSUE: state_next = ST_Y_WAIT;
            ST_Y_WAIT:  state_next = ST_Y_DAYS;
            ST_Y_DAYS:
            begin
                acc_next   = days_sum;
                state_next = ST_Y_HOURS;
            end
            ST_Y_HOURS:
            begin
                acc_next = hours_sum;
                if (phase_reg)
                    state_next = ST_DIFF;
                else
                begin
                    base_next  = hours_sum;
                    phase_next = 1'b1;
                    state_next = (op_reg == OP_OFFSET_TO_DATE) ? ST_OFF_ADD : ST_Y_ISSUE;
                end
            end
            ST_DIFF:
            begin
                out_offset_next = diff[31:0];
                out_day_next    = '0;
                out_month_next  = '0;
                out_year_next   = '0;
                out_hour_next   = '0;
                oor_next        = 1'b0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_OFF_ADD:
            begin
                acc_next = off_sum;
                if (off_sum[ACC_W-1])
                begin
                    // before year 0
                    out_offset_next = '0;
                    out_day_next    = '0;
                    out_month_next  = '0;
                    out_year_next   = '0;
                    out_hour_next   = '0;
                    oor_next        = 1'b1;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                    state_next = ST_DIV_MUL;
            end
            ST_DIV_MUL:
            begin
                days_next  = prod3[DIV3_SHIFT +: DAY_W];
                state_next = ST_DIV_REM;
            end
            ST_DIV_REM:
            begin
                hrs_next   = rem24[4:0];
                year_next  = '0;
                bit_next   = BIT_W'(YEAR_BITS);
                state_next = ST_S_ISSUE;
            end
            ST_S_ISSUE: state_next = ST_S_WAIT;
            ST_S_WAIT:  state_next = ST_S_CMP;
            ST_S_CMP:
            begin
                // top step probes the first year past the range
                if (bit_reg == BIT_W'(YEAR_BITS))
                begin
                    if (hit)
                    begin
                        out_offset_next = '0;
                        out_day_next    = '0;
                        out_month_next  = '0;
                        out_year_next   = '0;
                        out_hour_next   = '0;
                        oor_next        = 1'b1;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_S_ISSUE;
                    end
                end
                else
                begin
                    if (hit)
                        year_next = cand;
                    if (bit_reg == '0)
                        state_next = ST_M_ISSUE;
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_S_ISSUE;
                    end
                end
            end
            ST_M_ISSUE: state_next = ST_M_WAIT;
            ST_M_WAIT:  state_next = ST_M_SET;
            ST_M_SET:
            begin
                doy_next   = doy_full[DOY_W-1:0];
                leap_next  = yu_leap;
                mon_next   = 4'd1;
                state_next = ST_M_WALK;
            end
            ST_M_WALK:
            begin
                if (mon_reg < MONTHS_PER_YEAR && doy_reg >= DOY_W'(mlen))
                begin
                    doy_next = doy_reg - DOY_W'(mlen);
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    out_offset_next = '0;
                    out_day_next    = 5'(doy_reg + DOY_W'(1));
                    out_month_next  = mon_reg;
                    out_year_next   = year_reg[YEAR_BITS-1:0];
                    out_hour_next   = hrs_reg;
                    oor_next        = 1'b0;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        phase_reg      <= phase_next;
        day_in_reg     <= day_in_next;
        mon_in_reg     <= mon_in_next;
        yr_in_reg      <= yr_in_next;
        hr_in_reg      <= hr_in_next;
        off_reg        <= off_next;
        acc_reg        <= acc_next;
        base_reg       <= base_next;
        days_reg       <= days_next;
        hrs_reg        <= hrs_next;
        year_reg       <= year_next;
        bit_reg        <= bit_next;
        doy_reg        <= doy_next;
        mon_reg        <= mon_next;
        leap_reg       <= leap_next;
        out_offset_reg <= out_offset_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_hour_reg   <= out_hour_next;
        oor_reg        <= oor_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign out_offset   = out_offset_reg;
    assign out_day      = out_day_reg;
    assign out_month    = out_month_reg;
    assign out_year     = out_year_reg;
    assign out_hour     = out_hour_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== hw/rtl/calendar_hour_offset_converter.sv =====
// Top level of the Gregorian date / hour offset converter.
// Depends on cho_pkg, cho_regs, cho_year_unit and cho_core.
//
//   channel   handshake                       beat
//   config    psel/penable/pwrite/pready      one register write, addr 4*index
//   command   start && !busy                  opcode, date fields, in_offset
//   result    done (one cycle)                out_offset, date fields, out_of_range
//
// Opcode 0 runs the year unit for the reference and then for the input, and subtracts.
// Opcode 1 runs it for the reference, adds in_offset, divides by 24, finds the year by a
// binary search through the year unit and then walks the months. A negative result hour
// ends before the year search, with out_of_range set.
// busy is high from accept until done is raised; the receiver cannot stall.
// Reset is asynchronous, active low, and restores the reference to 1 Jan 2000, 00h.
`timescale 1ns / 1ps

module calendar_hour_offset_converter #(
    parameter int YEAR_BITS = cho_pkg::YEAR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cho_pkg::ADDR_W-1:0]  paddr,
    input  logic [cho_pkg::DATA_W-1:0]  pwdata,
    output logic [cho_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [4:0]                  in_day,
    input  logic [3:0]                  in_month,
    input  logic [YEAR_BITS-1:0]        in_year,
    input  logic [4:0]                  in_hour,
    input  logic signed [31:0]          in_offset,
    output logic                        done,
    output logic signed [31:0]          out_offset,
    output logic [4:0]                  out_day,
    output logic [3:0]                  out_month,
    output logic [YEAR_BITS-1:0]        out_year,
    output logic [4:0]                  out_hour,
    output logic                        out_of_range
);
    import cho_pkg::*;

    logic [4:0]           ref_day;
    logic [3:0]           ref_month;
    logic [YEAR_BITS-1:0] ref_year;
    logic [4:0]           ref_hour;
    logic [YEAR_BITS:0]   yu_year;
    logic [YEAR_BITS+8:0] yu_dby;
    logic                 yu_leap;

    cho_regs #(
        .YEAR_BITS (YEAR_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ref_day   (ref_day),
        .ref_month (ref_month),
        .ref_year  (ref_year),
        .ref_hour  (ref_hour)
    );

    cho_year_unit #(
        .YEAR_BITS (YEAR_BITS)
    ) u_year_unit (
        .clk  (clk),
        .year (yu_year),
        .dby  (yu_dby),
        .leap (yu_leap)
    );

    cho_core #(
        .YEAR_BITS (YEAR_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ref_day      (ref_day),
        .ref_month    (ref_month),
        .ref_year     (ref_year),
        .ref_hour     (ref_hour),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .in_day       (in_day),
        .in_month     (in_month),
        .in_year      (in_year),
        .in_hour      (in_hour),
        .in_offset    (in_offset),
        .yu_year      (yu_year),
        .yu_dby       (yu_dby),
        .yu_leap      (yu_leap),
        .done         (done),
        .out_offset   (out_offset),
        .out_day      (out_day),
        .out_month    (out_month),
        .out_year     (out_year),
        .out_hour     (out_hour),
        .out_of_range (out_of_range)
    );

endmodule
